// File: hdl/alhc_pkg.sv
// Package for the aging LFU handle cache: widths, register indexes and item types.
// Depends on nothing; alhc_eval, the top level and the testbench import it.
package alhc_pkg;

  // Fixed field widths.
  localparam int TAG_W      = 64;
  localparam int TIME_W     = 30;
  localparam int INC_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_NAME_BYTES = 8;
  localparam int DEF_COUNT_BITS = 24;

  // Register reset values.
  localparam logic [TIME_W-1:0] DECAY_WINDOW_RST = 30'd1000000;
  localparam logic [INC_W-1:0]  HIT_INC_RST      = 16'd100;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_INC      = 2'd1;

  // One request item.
  typedef struct packed {
    logic              req_type;
    logic [TAG_W-1:0]  key_tag;
    logic [TAG_W-1:0]  file_tag;
    logic [TIME_W-1:0] time_now_ns;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [TAG_W-1:0]  evicted_key_tag;
    logic [TAG_W-1:0]  evicted_file_tag;
  } out_item_t;

endpackage

// File: hdl/alhc_mem.sv
// Entry store of the handle cache: one write port, one registered read port.
// Depends on nothing but its parameters.
module alhc_mem #(
  parameter int ADDR_W = 5,
  parameter int DATA_W = 182
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/alhc_eval.sv
// Shared entry update unit: ages one entry, checks its tags and applies a hit.
// Depends on alhc_pkg for the field widths.
module alhc_eval #(
  parameter int COUNT_BITS = 24
) (
  input  logic [COUNT_BITS-1:0]       entry_count,
  input  logic [alhc_pkg::TIME_W-1:0] entry_time,
  input  logic [alhc_pkg::TAG_W-1:0]  entry_key,
  input  logic [alhc_pkg::TAG_W-1:0]  entry_file,
  input  logic [alhc_pkg::TAG_W-1:0]  req_key,
  input  logic [alhc_pkg::TAG_W-1:0]  req_file,
  input  logic [alhc_pkg::TIME_W-1:0] now,
  input  logic [alhc_pkg::TIME_W-1:0] window,
  input  logic [alhc_pkg::INC_W-1:0]  inc,
  input  logic                        hit_seen,
  output logic                        match,
  output logic [COUNT_BITS-1:0]       new_count,
  output logic [alhc_pkg::TIME_W-1:0] new_time,
  output logic [COUNT_BITS-1:0]       init_count
);
  import alhc_pkg::*;

  localparam int SUM_W = ((COUNT_BITS > INC_W) ? COUNT_BITS : INC_W) + 1;
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_BITS{1'b1}});

  logic signed [TIME_W:0] diff;
  logic                   aged;
  logic [COUNT_BITS-1:0]  aged_count;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_BITS-1:0]  sat_count;
  logic [SUM_W-1:0]       init_ext;

  // Ageing: a signed idle time beyond the window takes one off a nonzero count.
  assign diff       = $signed({1'b0, now}) - $signed({1'b0, entry_time});
  assign aged       = (diff > $signed({1'b0, window})) && (entry_count != '0);
  assign aged_count = entry_count - COUNT_BITS'(aged);

  // Only the first matching entry of a walk counts as the hit.
  assign match = (entry_key == req_key) && (entry_file == req_file) && !hit_seen;

  // Saturating add of the increment.
  assign sum       = SUM_W'(aged_count) + SUM_W'(inc);
  assign sat_count = (sum > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];

  assign new_count = match ? sat_count : aged_count;
  assign new_time  = match ? now : entry_time;

  // Starting count of a newly placed entry.
  assign init_ext   = SUM_W'(inc);
  assign init_count = (init_ext > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                             : init_ext[COUNT_BITS-1:0];

endmodule

// File: hdl/aging_lfu_handle_cache.sv
// Aging LFU handle cache: two fully associative tables (read and write handles)
// of ENTRIES entries each, tagged by key and file name tags.
// Channels: in_* takes one lookup item (table, key tag, file tag, time); out_*
// returns one result item per lookup (hit, slot, eviction and evicted tags);
// cfg_* writes the decay window (index 0) and the hit increment (index 1) and
// is always ready. Configuration is expected only while no lookup is in flight.
// Walk: a lookup walks the filled entries of its table through one shared
// update unit, one entry per cycle, fed by an entry memory with one write
// port and one registered read port. Each entry is read, aged, checked and
// written back, then weighed for the lowest count; a final step offers the
// result. A lookup into an empty table goes from the walk to the final step.
// in_ready is high only while the sequencer is idle, so one item is handled
// at a time. The result sits in an output register; the next item may be
// accepted while it waits, but the walk holds before its final write until
// the receiver has taken the previous result.
// Reset empties both tables and restores the register defaults; no clearing
// pass is needed, as only entries below the fill count are ever read.
// Depends on alhc_pkg, alhc_mem and alhc_eval.
module aging_lfu_handle_cache #(
  parameter int ENTRIES    = alhc_pkg::DEF_ENTRIES,
  parameter int NAME_BYTES = alhc_pkg::DEF_NAME_BYTES,
  parameter int COUNT_BITS = alhc_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  alhc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output alhc_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alhc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alhc_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENT_W  = 2 * TAG_W + COUNT_BITS + TIME_W;
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Name tag: bytes up to the first zero byte and within NAME_BYTES.
  function automatic logic [TAG_W-1:0] name_of(input logic [TAG_W-1:0] tag);
    logic [TAG_W-1:0] r;
    logic             keep;
    r    = '0;
    keep = 1'b1;
    for (int b = 0; b < TAG_W / 8; b++) begin
      keep = keep && (b < NAME_BYTES) && (tag[8*b +: 8] != 8'd0);
      if (keep) begin
        r[8*b +: 8] = tag[8*b +: 8];
      end
    end
    return r;
  endfunction

  // Control registers.
  logic [1:0]        state_r, state_nxt;
  logic [TIME_W-1:0] window_r, window_nxt;
  logic [INC_W-1:0]  inc_r, inc_nxt;
  logic [CNT_W-1:0]  occ_r [2];
  logic [CNT_W-1:0]  occ_nxt [2];
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              p1_vld_r, p1_vld_nxt;
  logic              cand_vld_r, cand_vld_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic                  req_type_r, req_type_nxt;
  logic [TAG_W-1:0]      req_key_r, req_key_nxt;
  logic [TAG_W-1:0]      req_file_r, req_file_nxt;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [IDX_W-1:0]      p1_idx_r, p1_idx_nxt;
  logic [IDX_W-1:0]      cand_idx_r, cand_idx_nxt;
  logic [COUNT_BITS-1:0] cand_count_r, cand_count_nxt;
  logic [TAG_W-1:0]      cand_key_r, cand_key_nxt;
  logic [TAG_W-1:0]      cand_file_r, cand_file_nxt;
  logic [IDX_W-1:0]      min_idx_r, min_idx_nxt;
  logic [COUNT_BITS-1:0] min_count_r, min_count_nxt;
  logic [TAG_W-1:0]      min_key_r, min_key_nxt;
  logic [TAG_W-1:0]      min_file_r, min_file_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  out_item_t             out_r, out_nxt;

  // Datapath signals.
  logic                    in_acc;
  logic                    issue;
  logic                    out_free;
  logic                    commit;
  logic                    full;
  logic [IDX_W-1:0]        new_idx;
  logic [IDX_W-1:0]        slot_idx;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic                    mem_wr_en;
  logic [ADDR_W-1:0]       mem_wr_addr;
  logic [ENT_W-1:0]        mem_wr_data;
  logic [ADDR_W-1:0]       mem_rd_addr;
  logic [ENT_W-1:0]        mem_rd_data;
  logic [TAG_W-1:0]        ent_key;
  logic [TAG_W-1:0]        ent_file;
  logic [COUNT_BITS-1:0]   ent_count;
  logic [TIME_W-1:0]       ent_time;
  logic                    ev_match;
  logic [COUNT_BITS-1:0]   ev_count;
  logic [TIME_W-1:0]       ev_time;
  logic [COUNT_BITS-1:0]   init_count;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign issue    = (state_r == ST_WALK) && (rd_idx_r < n_r);
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_FINISH) && out_free;
  assign full     = (n_r >= ENTRIES_C);
  assign new_idx  = full ? min_idx_r : n_r[IDX_W-1:0];
  assign slot_idx = hit_r ? hit_idx_r : new_idx;
  assign slot_ext = {{SLOT_W{1'b0}}, slot_idx};

  // Entry fields as read from the store.
  assign ent_key   = mem_rd_data[ENT_W-1 -: TAG_W];
  assign ent_file  = mem_rd_data[ENT_W-TAG_W-1 -: TAG_W];
  assign ent_count = mem_rd_data[TIME_W +: COUNT_BITS];
  assign ent_time  = mem_rd_data[TIME_W-1:0];

  assign mem_rd_addr = {req_type_r, rd_idx_r[IDX_W-1:0]};

  // The walk writes back each aged entry; the final step writes a new entry on a miss.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = {req_type_r, p1_idx_r};
    mem_wr_data = {ent_key, ent_file, ev_count, ev_time};
    if (p1_vld_r) begin
      mem_wr_en = 1'b1;
    end else if (commit && !hit_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = {req_type_r, new_idx};
      mem_wr_data = {req_key_r, req_file_r, init_count, now_r};
    end
  end

  alhc_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (issue),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  alhc_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .entry_count (ent_count),
    .entry_time  (ent_time),
    .entry_key   (ent_key),
    .entry_file  (ent_file),
    .req_key     (req_key_r),
    .req_file    (req_file_r),
    .now         (now_r),
    .window      (window_r),
    .inc         (inc_r),
    .hit_seen    (hit_r),
    .match       (ev_match),
    .new_count   (ev_count),
    .new_time    (ev_time),
    .init_count  (init_count)
  );

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    window_nxt     = window_r;
    inc_nxt        = inc_r;
    occ_nxt        = occ_r;
    rd_idx_nxt     = rd_idx_r;
    p1_vld_nxt     = issue;
    p1_idx_nxt     = rd_idx_r[IDX_W-1:0];
    cand_vld_nxt   = p1_vld_r;
    cand_idx_nxt   = p1_idx_r;
    cand_count_nxt = ev_count;
    cand_key_nxt   = ent_key;
    cand_file_nxt  = ent_file;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    min_idx_nxt    = min_idx_r;
    min_count_nxt  = min_count_r;
    min_key_nxt    = min_key_r;
    min_file_nxt   = min_file_r;
    req_type_nxt   = req_type_r;
    req_key_nxt    = req_key_r;
    req_file_nxt   = req_file_r;
    now_nxt        = now_r;
    n_nxt          = n_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    // Configuration writes.
    if (cfg_valid) begin
      case (cfg_index)
        REG_DECAY_WINDOW: window_nxt = cfg_data[TIME_W-1:0];
        REG_HIT_INC:      inc_nxt    = cfg_data[INC_W-1:0];
        default:          ;
      endcase
    end

    // Read pointer of the walk.
    if (issue) begin
      rd_idx_nxt = rd_idx_r + CNT_W'(1);
    end

    // First matching entry of the walk.
    if (p1_vld_r && ev_match) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = p1_idx_r;
    end

    // Lowest count so far; the lower index wins ties.
    if (cand_vld_r && ((cand_idx_r == '0) || (cand_count_r < min_count_r))) begin
      min_idx_nxt   = cand_idx_r;
      min_count_nxt = cand_count_r;
      min_key_nxt   = cand_key_r;
      min_file_nxt  = cand_file_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt    = ST_WALK;
          req_type_nxt = in_data.req_type;
          req_key_nxt  = name_of(in_data.key_tag);
          req_file_nxt = name_of(in_data.file_tag);
          now_nxt      = in_data.time_now_ns;
          n_nxt        = occ_r[in_data.req_type];
          rd_idx_nxt   = '0;
          hit_nxt      = 1'b0;
        end
      end
      ST_WALK: begin
        if (!issue && !p1_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt                = ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_nxt.hit              = hit_r;
          out_nxt.slot             = slot_ext[SLOT_W-1:0];
          out_nxt.evicted          = !hit_r && full;
          out_nxt.evicted_key_tag  = (!hit_r && full) ? min_key_r : '0;
          out_nxt.evicted_file_tag = (!hit_r && full) ? min_file_r : '0;
          if (!hit_r && !full) begin
            occ_nxt[req_type_r] = n_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= DECAY_WINDOW_RST;
      inc_r       <= HIT_INC_RST;
      occ_r[0]    <= '0;
      occ_r[1]    <= '0;
      rd_idx_r    <= '0;
      p1_vld_r    <= 1'b0;
      cand_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      inc_r       <= inc_nxt;
      occ_r       <= occ_nxt;
      rd_idx_r    <= rd_idx_nxt;
      p1_vld_r    <= p1_vld_nxt;
      cand_vld_r  <= cand_vld_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    req_key_r    <= req_key_nxt;
    req_file_r   <= req_file_nxt;
    now_r        <= now_nxt;
    n_r          <= n_nxt;
    p1_idx_r     <= p1_idx_nxt;
    cand_idx_r   <= cand_idx_nxt;
    cand_count_r <= cand_count_nxt;
    cand_key_r   <= cand_key_nxt;
    cand_file_r  <= cand_file_nxt;
    min_idx_r    <= min_idx_nxt;
    min_count_r  <= min_count_nxt;
    min_key_r    <= min_key_nxt;
    min_file_r   <= min_file_nxt;
    hit_idx_r    <= hit_idx_nxt;
    out_r        <= out_nxt;
  end

  // Neither table ever holds more than ENTRIES entries.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r[0] <= ENTRIES_C) && (occ_r[1] <= ENTRIES_C))
    else $error("table fill count beyond capacity");

  // A result only appears out of the final step of a walk.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside the final step");

  // A miss into a free slot grows its table by exactly one.
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !hit_r && !full) |=>
      (occ_r[$past(req_type_r)] == ($past(n_r) + CNT_W'(1))))
    else $error("fill count not advanced after a miss");

  // The walk pipeline is drained whenever a new item may be taken.
  a_drained_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!p1_vld_r && !cand_vld_r))
    else $error("walk pipeline busy while idle");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the aging LFU handle cache: lookups, register writes, ageing.
// Depends on alhc_pkg and aging_lfu_handle_cache; holds its own model of both tables.
`timescale 1ns / 1ps

module testbench;
  import alhc_pkg::*;

  localparam int ENTRIES    = 16;
  localparam int NAME_BYTES = 8;
  localparam int COUNT_W    = 24;
  localparam int POOL       = 20;
  localparam int SETTLE     = 24;
  localparam int SHOWN      = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Model of both tables and of the two registers.
  logic [TAG_W-1:0]   held_key   [2][ENTRIES];
  logic [TAG_W-1:0]   held_file  [2][ENTRIES];
  logic [COUNT_W-1:0] use_cnt    [2][ENTRIES];
  logic [TIME_W-1:0]  touched_at [2][ENTRIES];
  int                 fill_count [2];
  logic [TIME_W-1:0]  decay_window;
  logic [INC_W-1:0]   hit_inc;

  out_item_t          pending_results[$];
  logic [TAG_W-1:0]   key_pool  [POOL];
  logic [TAG_W-1:0]   file_pool [POOL];
  int                 errors;
  int                 results_seen;
  int                 clock_ns;
  bit                 quiet;

  aging_lfu_handle_cache #(
    .ENTRIES   (ENTRIES),
    .NAME_BYTES(NAME_BYTES),
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #8_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // A tag names only the bytes up to its first zero byte.
  function automatic logic [TAG_W-1:0] name_bytes(logic [TAG_W-1:0] tag);
    logic [TAG_W-1:0] name;
    name = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (tag[8*b +: 8] == 8'h00) break;
      name[8*b +: 8] = tag[8*b +: 8];
    end
    return name;
  endfunction

  function automatic logic [COUNT_W-1:0] count_add(logic [COUNT_W-1:0] c,
                                                   logic [INC_W-1:0] d);
    logic [COUNT_W:0] sum;
    sum = c + d;
    return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  endfunction

  // Walks one table as the block does and returns the result it should give.
  function automatic out_item_t predict_lookup(in_item_t it);
    out_item_t        res;
    int               tbl;
    int               n;
    int               low_idx;
    logic [COUNT_W-1:0] low_cnt;
    logic [TAG_W-1:0] key;
    logic [TAG_W-1:0] fil;
    longint           span;
    bit               found;
    res     = '0;
    tbl     = int'(it.req_type);
    key     = name_bytes(it.key_tag);
    fil     = name_bytes(it.file_tag);
    n       = fill_count[tbl];
    found   = 1'b0;
    low_idx = 0;
    low_cnt = '0;
    for (int i = 0; i < n; i++) begin
      span = longint'(it.time_now_ns) - longint'(touched_at[tbl][i]);
      if (span > longint'(decay_window) && use_cnt[tbl][i] != '0) begin
        use_cnt[tbl][i] = use_cnt[tbl][i] - 1'b1;
      end
      if (!found && held_key[tbl][i] == key && held_file[tbl][i] == fil) begin
        found              = 1'b1;
        res.hit            = 1'b1;
        res.slot           = SLOT_W'(i);
        use_cnt[tbl][i]    = count_add(use_cnt[tbl][i], hit_inc);
        touched_at[tbl][i] = it.time_now_ns;
      end
      if (i == 0 || use_cnt[tbl][i] < low_cnt) begin
        low_cnt = use_cnt[tbl][i];
        low_idx = i;
      end
    end
    if (!found) begin
      if (n >= ENTRIES) begin
        res.slot             = SLOT_W'(low_idx);
        res.evicted          = 1'b1;
        res.evicted_key_tag  = held_key[tbl][low_idx];
        res.evicted_file_tag = held_file[tbl][low_idx];
      end else begin
        res.slot        = SLOT_W'(n);
        low_idx         = n;
        fill_count[tbl] = n + 1;
      end
      if (res.evicted) begin
        low_idx = low_idx;
      end
      held_key[tbl][low_idx]   = key;
      held_file[tbl][low_idx]  = fil;
      use_cnt[tbl][low_idx]    = count_add('0, hit_inc);
      touched_at[tbl][low_idx] = it.time_now_ns;
    end
    return res;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A name of random length made of non-zero bytes.
  function automatic logic [TAG_W-1:0] make_name();
    logic [TAG_W-1:0] name;
    int len;
    name = '0;
    len  = $urandom_range(0, NAME_BYTES);
    for (int b = 0; b < len; b++) name[8*b +: 8] = 8'($urandom_range(1, 255));
    return name;
  endfunction

  // Fills the bytes after a name's terminator with random rubbish now and then.
  function automatic logic [TAG_W-1:0] dress_tag(logic [TAG_W-1:0] name);
    logic [TAG_W-1:0] tag;
    tag = name;
    for (int b = 0; b < 8; b++) begin
      if (name[8*b +: 8] == 8'h00) begin
        for (int j = b + 1; j < 8; j++) begin
          if ($urandom_range(0, 1) == 1) tag[8*j +: 8] = 8'($urandom_range(0, 255));
        end
        break;
      end
    end
    return tag;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= SHOWN) $display("%s", msg);
  endtask

  task automatic check_field(int idx, string field, logic [TAG_W-1:0] got,
                             logic [TAG_W-1:0] want);
    if (got !== want) begin
      note_failure($sformatf("result %0d: %s expected %h, got %h", idx, field, want, got));
    end
  endtask

  // Each accepted result item is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with none expected: %p",
                               results_seen, out_data));
      end else begin
        want = pending_results.pop_front();
        check_field(results_seen, "hit", TAG_W'(out_data.hit), TAG_W'(want.hit));
        check_field(results_seen, "slot", TAG_W'(out_data.slot), TAG_W'(want.slot));
        check_field(results_seen, "evicted", TAG_W'(out_data.evicted),
                    TAG_W'(want.evicted));
        check_field(results_seen, "evicted_key_tag", out_data.evicted_key_tag,
                    want.evicted_key_tag);
        check_field(results_seen, "evicted_file_tag", out_data.evicted_file_tag,
                    want.evicted_file_tag);
      end
      results_seen++;
    end
  end

  // Receiver: takes results, with stalls of random length.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Offers one lookup item and records its expected result once accepted.
  task automatic send_lookup(in_item_t it);
    int gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_lookup(it));
  endtask

  task automatic send_fields(bit tbl, logic [TAG_W-1:0] key, logic [TAG_W-1:0] fil,
                             int t_ns);
    in_item_t it;
    it.req_type    = tbl;
    it.key_tag     = key;
    it.file_tag    = fil;
    it.time_now_ns = TIME_W'(t_ns);
    send_lookup(it);
  endtask

  // Stops offering items and waits until the block has nothing left in hand.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DECAY_WINDOW: decay_window = value[TIME_W-1:0];
      REG_HIT_INC:      hit_inc      = value[INC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int window, int inc);
    drain();
    write_reg(REG_DECAY_WINDOW, CFG_DATA_W'(window));
    write_reg(REG_HIT_INC, CFG_DATA_W'(inc));
  endtask

  // Moves the lookup clock on: small steps, steps past the window, and jumps back.
  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      clock_ns = (clock_ns + $urandom_range(0, 2000)) % 1000000000;
    else if (r < 80) clock_ns = (clock_ns + $urandom_range(0, 3000000)) % 1000000000;
    else if (r < 95) clock_ns = (clock_ns + $urandom_range(0, 400000000)) % 1000000000;
    else             clock_ns = $urandom_range(0, 999999999);
  endtask

  // Random lookups, mostly over a small set of names so that hits and evictions occur.
  task automatic run_random(int count);
    in_item_t it;
    int pick;
    int r;
    for (int k = 0; k < count; k++) begin
      if (k % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick        = $urandom_range(0, POOL - 1);
      r           = $urandom_range(0, 99);
      it.req_type = 1'($urandom_range(0, 1));
      if (r < 75) begin
        it.key_tag  = dress_tag(key_pool[pick]);
        it.file_tag = dress_tag(file_pool[pick]);
      end else if (r < 85) begin
        it.key_tag  = dress_tag(key_pool[pick]);
        it.file_tag = dress_tag(file_pool[$urandom_range(0, POOL - 1)]);
      end else begin
        it.key_tag  = {$urandom, $urandom};
        it.file_tag = {$urandom, $urandom};
      end
      advance_clock();
      it.time_now_ns = TIME_W'(clock_ns);
      send_lookup(it);
    end
    quiet = 1'b0;
  endtask

  // Filling, hits, tag bytes after the terminator, a full table and a clock going back.
  task automatic test_lookup_basics();
    logic [TAG_W-1:0] nm;
    quiet = 1'b1;
    send_fields(1'b0, '1, '1, 0);
    send_fields(1'b0, '0, '0, 5);
    send_fields(1'b1, '1, '1, 999999999);
    send_fields(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 64'h1234_5678_0000_0000, 10);
    send_fields(1'b0, 64'h0000_0000_00AB_0041, 64'h0, 2000000);
    send_fields(1'b0, '1, '1, 4000000);
    quiet = 1'b0;
    for (int k = 0; k < 13; k++) begin
      nm = 64'h0000_0000_0000_4600 | 64'(k + 1);
      send_fields(1'b0, nm, nm, 6000000 + k * 1500000);
    end
    send_fields(1'b0, 64'h0000_0000_0000_5A5A, 64'h0000_0000_0000_0001, 40000000);
    send_fields(1'b0, 64'h0000_0000_0000_0041, 64'h0, 3000);
    send_fields(1'b1, 64'h0000_0000_00AB_0041, 64'hFF00_0000_0000_0000, 0);
  endtask

  // Register settings at their extremes, including an increment of zero.
  task automatic test_registers();
    set_config(0, 65535);
    run_random(30);
    set_config(999999999, 1);
    run_random(30);
    set_config(0, 0);
    run_random(30);
    set_config(1000, 100);
    run_random(30);
  endtask

  // Repeated hits drive one count to its ceiling; it then outlives later misses.
  task automatic test_count_saturation();
    set_config(999999999, 65535);
    for (int k = 0; k < 260; k++) begin
      send_fields(1'b0, 64'h0000_0000_0053_4154, 64'h0000_0000_0000_7A7A, 500);
    end
    set_config(0, 1);
    for (int k = 0; k < 20; k++) begin
      clock_ns = 1000 + k * 10;
      send_fields(1'b0, make_name(), make_name(), clock_ns);
    end
  endtask

  // Long random runs under several settings.
  task automatic test_random_traffic();
    set_config(50000, 3);
    run_random(200);
    set_config(999999999, 65535);
    run_random(200);
    set_config(0, 1);
    run_random(200);
    set_config(1000000, 100);
    run_random(200);
  endtask

  // Test sequence.
  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DECAY_WINDOW;
    cfg_data     = '0;
    errors       = 0;
    results_seen = 0;
    clock_ns     = 0;
    quiet        = 1'b0;
    fill_count   = '{0, 0};
    decay_window = DECAY_WINDOW_RST;
    hit_inc      = HIT_INC_RST;
    for (int p = 0; p < POOL; p++) begin
      key_pool[p]  = make_name();
      file_pool[p] = make_name();
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_lookup_basics();
    test_registers();
    test_count_saturation();
    test_random_traffic();
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: aging_lfu_handle_cache.f
hdl/alhc_pkg.sv
hdl/alhc_mem.sv
hdl/alhc_eval.sv
hdl/aging_lfu_handle_cache.sv
tb/testbench.sv
